FILE: hdl/toap_pkg.sv
// Package for the TFTP option-acknowledge parser: word types, option codes,
// register indexes and the option name table.
// Depends on nothing; used by toap_parser and tftp_option_ack_parser_core.
`default_nettype none

package toap_pkg;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  option_kind;
        logic [30:0] option_value;
        logic        matches_request;
        logic        packet_end;
    } out_word_t;

    typedef struct packed {
        logic [15:0] requested_block_size;
        logic [7:0]  timeout_request;
        logic [30:0] transfer_size;
    } cfg_regs_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } result_t;

    typedef enum logic [2:0] {
        PH_OPCODE = 3'b001,
        PH_NAME   = 3'b010,
        PH_VALUE  = 3'b100
    } phase_t;

    localparam logic [1:0] OPT_BLKSIZE = 2'd0;
    localparam logic [1:0] OPT_TIMEOUT = 2'd1;
    localparam logic [1:0] OPT_TSIZE   = 2'd2;
    localparam logic [1:0] OPT_NONE    = 2'd3;

    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLKSIZE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TSIZE   = 2'd2;

    localparam int unsigned CFG_DATA_BITS = 31;
    localparam int unsigned NUM_CAND      = 3;

    localparam logic [2:0]  ALL_LIVE     = 3'b111;
    localparam logic [15:0] BLKSIZE_RST  = 16'd512;

    localparam logic [63:0] CAND_TEXT [NUM_CAND] = '{
        {"blksize", 8'h00},
        {"timeout", 8'h00},
        {"tsize",   24'h000000}
    };

    localparam logic [3:0] CAND_LEN [NUM_CAND] = '{4'd7, 4'd7, 4'd5};

    function automatic logic [7:0] cand_char(input logic [1:0] idx, input logic [2:0] pos);
        logic [63:0] text;
        begin
            text = CAND_TEXT[idx];
            cand_char = text[8*(7-pos) +: 8];
        end
    endfunction

endpackage

`default_nettype wire

FILE: hdl/toap_parser.sv
// Parse state of the option-acknowledge parser: opcode skip, name match and
// decimal value accumulation, one packet byte per step.
// Depends on toap_pkg.
`default_nettype none

module toap_parser #(
    parameter int unsigned VALUE_BITS = 31
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step_en,
    input  wire toap_pkg::in_word_t word_in,
    input  wire toap_pkg::cfg_regs_t cfg,
    output toap_pkg::result_t       res
);

    localparam int unsigned WIDE_BITS = VALUE_BITS + 4;

    toap_pkg::phase_t       phase_reg, phase_next;
    logic                   opcode_seen_reg, opcode_seen_next;
    logic [3:0]             pos_reg, pos_next;
    logic [2:0]             cand_reg, cand_next;
    logic [VALUE_BITS-1:0]  acc_reg, acc_next;
    logic                   stopped_reg, stopped_next;
    logic [1:0]             option_reg, option_next;

    logic                   byte_zero;
    logic                   is_digit;
    logic [WIDE_BITS-1:0]   acc_wide;
    logic [WIDE_BITS-1:0]   acc_sum;
    logic [VALUE_BITS-1:0]  acc_sat;
    logic [VALUE_BITS-1:0]  acc_upd;
    logic [2:0]             cand_ok;
    logic [1:0]             name_option;
    logic [31:0]            req_value;
    logic                   match;
    logic                   emit;
    logic                   emit_end;

    always_comb begin
        byte_zero = (word_in.packet_byte == 8'h00);
        is_digit  = (word_in.packet_byte >= 8'h30) && (word_in.packet_byte <= 8'h39);
        acc_wide  = WIDE_BITS'(acc_reg);
        acc_sum   = (acc_wide << 3) + (acc_wide << 1)
                  + WIDE_BITS'(word_in.packet_byte[3:0]);
        acc_sat   = (acc_sum[WIDE_BITS-1:VALUE_BITS] != '0) ? {VALUE_BITS{1'b1}}
                                                             : acc_sum[VALUE_BITS-1:0];
        acc_upd   = (!byte_zero && !stopped_reg && is_digit) ? acc_sat : acc_reg;

        for (int i = 0; i < toap_pkg::NUM_CAND; i++) begin
            cand_ok[i] = (pos_reg < toap_pkg::CAND_LEN[i])
                      && (toap_pkg::cand_char(2'(i), pos_reg[2:0]) == word_in.packet_byte);
        end

        name_option = toap_pkg::OPT_NONE;
        for (int i = toap_pkg::NUM_CAND - 1; i >= 0; i--) begin
            if (cand_reg[i] && (pos_reg == toap_pkg::CAND_LEN[i])) begin
                name_option = 2'(i);
            end
        end

        case (option_reg)
            toap_pkg::OPT_BLKSIZE: req_value = 32'(cfg.requested_block_size);
            toap_pkg::OPT_TIMEOUT: req_value = 32'(cfg.timeout_request);
            default:               req_value = 32'(cfg.transfer_size);
        endcase
        match = (32'(acc_upd) == req_value);
    end

    always_comb begin
        phase_next       = phase_reg;
        opcode_seen_next = opcode_seen_reg;
        pos_next         = pos_reg;
        cand_next        = cand_reg;
        acc_next         = acc_reg;
        stopped_next     = stopped_reg;
        option_next      = option_reg;
        emit             = 1'b0;
        emit_end         = 1'b0;

        case (phase_reg)
            toap_pkg::PH_OPCODE: begin
                if (!opcode_seen_reg) begin
                    opcode_seen_next = 1'b1;
                end else begin
                    phase_next   = toap_pkg::PH_NAME;
                    pos_next     = '0;
                    cand_next    = toap_pkg::ALL_LIVE;
                    acc_next     = '0;
                    stopped_next = 1'b0;
                    option_next  = toap_pkg::OPT_NONE;
                end
            end
            toap_pkg::PH_NAME: begin
                if (byte_zero) begin
                    phase_next   = toap_pkg::PH_VALUE;
                    option_next  = name_option;
                    acc_next     = '0;
                    stopped_next = 1'b0;
                end else begin
                    cand_next = cand_reg & cand_ok;
                    pos_next  = (pos_reg == 4'hF) ? pos_reg : pos_reg + 4'd1;
                end
            end
            toap_pkg::PH_VALUE: begin
                if (byte_zero) begin
                    emit         = (option_reg != toap_pkg::OPT_NONE);
                    emit_end     = word_in.final_byte;
                    phase_next   = toap_pkg::PH_NAME;
                    pos_next     = '0;
                    cand_next    = toap_pkg::ALL_LIVE;
                    acc_next     = '0;
                    stopped_next = 1'b0;
                    option_next  = toap_pkg::OPT_NONE;
                end else begin
                    acc_next     = acc_upd;
                    stopped_next = stopped_reg | ~is_digit;
                    emit         = word_in.final_byte && (option_reg != toap_pkg::OPT_NONE);
                    emit_end     = 1'b1;
                end
            end
            default: begin
                phase_next       = toap_pkg::PH_OPCODE;
                opcode_seen_next = 1'b0;
            end
        endcase

        if (word_in.final_byte) begin
            phase_next       = toap_pkg::PH_OPCODE;
            opcode_seen_next = 1'b0;
            pos_next         = '0;
            cand_next        = toap_pkg::ALL_LIVE;
            acc_next         = '0;
            stopped_next     = 1'b0;
            option_next      = toap_pkg::OPT_NONE;
        end

        res.valid = emit || word_in.final_byte;
        if (emit) begin
            res.word.option_kind     = option_reg;
            res.word.option_value    = 31'(acc_upd);
            res.word.matches_request = match;
            res.word.packet_end      = emit_end;
        end else begin
            res.word.option_kind     = toap_pkg::OPT_NONE;
            res.word.option_value    = '0;
            res.word.matches_request = 1'b0;
            res.word.packet_end      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= toap_pkg::PH_OPCODE;
            opcode_seen_reg <= 1'b0;
            pos_reg         <= '0;
            cand_reg        <= toap_pkg::ALL_LIVE;
            acc_reg         <= '0;
            stopped_reg     <= 1'b0;
            option_reg      <= toap_pkg::OPT_NONE;
        end else if (step_en) begin
            phase_reg       <= phase_next;
            opcode_seen_reg <= opcode_seen_next;
            pos_reg         <= pos_next;
            cand_reg        <= cand_next;
            acc_reg         <= acc_next;
            stopped_reg     <= stopped_next;
            option_reg      <= option_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tftp_option_ack_parser_core.sv
// Top level of the TFTP option-acknowledge parser: input register, configuration
// registers, parser step and result register. Depends on toap_pkg, toap_parser.
// A byte accepted into the input register is stepped through the parser, and any result
// word it gives is loaded into the result register, which drives m_data.
// Throughput: one byte per cycle; s_ready falls only while both registers are full
// and m_ready is low.
// Reset (aresetn low, synchronous): parser back to opcode skip, both registers empty,
// block size 512, timeout 0, transfer size 0.
`default_nettype none

module tftp_option_ack_parser_core #(
    parameter int unsigned VALUE_BITS = 31
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire toap_pkg::in_word_t                     s_data,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output toap_pkg::out_word_t                         m_data,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [toap_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [toap_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    logic                 in_valid_reg, in_valid_next;
    toap_pkg::in_word_t   in_word_reg;
    logic                 m_valid_reg, m_valid_next;
    toap_pkg::out_word_t  m_word_reg;
    toap_pkg::cfg_regs_t  cfg_reg;
    toap_pkg::result_t    res;
    logic                 advance;
    logic                 step;
    logic                 s_fire;

    assign advance   = !m_valid_reg || m_ready;
    assign step      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_word_reg;

    toap_parser #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step),
        .word_in (in_word_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = step && res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_word_reg <= s_data;
        end
        if (step && res.valid) begin
            m_word_reg <= res.word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.requested_block_size <= toap_pkg::BLKSIZE_RST;
            cfg_reg.timeout_request      <= '0;
            cfg_reg.transfer_size        <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                toap_pkg::CFG_BLKSIZE: cfg_reg.requested_block_size <= cfg_data[15:0];
                toap_pkg::CFG_TIMEOUT: cfg_reg.timeout_request      <= cfg_data[7:0];
                toap_pkg::CFG_TSIZE:   cfg_reg.transfer_size        <= cfg_data;
                default: ;
            endcase
        end
    end

    a_final_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        step && in_word_reg.final_byte |=> m_valid_reg && m_word_reg.packet_end)
        else $error("final byte produced no end word");

    a_rise_after_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(step))
        else $error("result word appeared without a parser step");

    a_mid_packet_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_word_reg.packet_end |-> m_word_reg.option_kind != toap_pkg::OPT_NONE)
        else $error("end marker without packet end");

    a_marker_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_word_reg.option_kind == toap_pkg::OPT_NONE)
        |-> (m_word_reg.option_value == '0) && !m_word_reg.matches_request)
        else $error("end marker carries a value");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_word_reg))
        else $error("stalled input word lost");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for tftp_option_ack_parser_core: feeds directed and random OACK
// packets byte by byte, predicts each result word and compares it field by field.
// Depends on toap_pkg and the parser RTL; needs no files or arguments.

module tb_top;

    localparam int unsigned VALUE_BITS = 31;
    localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 1;
    localparam int CLK_PERIOD = 10;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD = 300;
    localparam int NUM_PHASES = 8;
    localparam int BYTES_PER_PHASE = 112;
    localparam logic [7:0] DIGIT_0 = 8'h30;
    localparam logic [7:0] DIGIT_9 = 8'h39;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    toap_pkg::in_word_t                  s_data = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    toap_pkg::out_word_t                 m_data;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [toap_pkg::CFG_INDEX_BITS-1:0] cfg_index = toap_pkg::CFG_BLKSIZE;
    logic [toap_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    tftp_option_ack_parser_core #(.VALUE_BITS(VALUE_BITS)) uut (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // parser prediction state
    toap_pkg::cfg_regs_t req_regs;
    toap_pkg::phase_t    ph;
    logic                opcode_seen;
    logic [3:0]          name_pos;
    logic [2:0]          live;
    logic [30:0]         acc;
    logic                digits_done;
    logic [1:0]          cur_opt;

    toap_pkg::out_word_t reports_due [$];
    toap_pkg::in_word_t  bytes_to_send [$];
    logic [7:0]          pkt [$];

    int bytes_queued = 0;
    int bytes_accepted = 0;
    int packets_queued = 0;
    int reg_writes = 0;
    int words_checked = 0;
    int matched_seen = 0;
    int markers_seen = 0;
    int failures = 0;
    int idle_cycles = 0;

    int tx_gap_max = 0;
    int rx_stall_pct = 0;
    int holds_asked = 0;
    int holds_done = 0;
    int hold_left = 0;
    int stall_left = 0;
    int burst_left = 0;
    int gap_left = 0;

    function automatic string option_name(input logic [1:0] opt);
        case (opt)
            toap_pkg::OPT_BLKSIZE: return "blksize";
            toap_pkg::OPT_TIMEOUT: return "timeout";
            default:               return "tsize";
        endcase
    endfunction

    task automatic open_name();
        ph = toap_pkg::PH_NAME;
        name_pos = '0;
        live = toap_pkg::ALL_LIVE;
        acc = '0;
        digits_done = 1'b0;
        cur_opt = toap_pkg::OPT_NONE;
    endtask

    task automatic clear_parse();
        open_name();
        ph = toap_pkg::PH_OPCODE;
        opcode_seen = 1'b0;
    endtask

    function automatic toap_pkg::out_word_t value_report(input logic last);
        toap_pkg::out_word_t r;
        logic [30:0]         want;
        case (cur_opt)
            toap_pkg::OPT_BLKSIZE: want = 31'(req_regs.requested_block_size);
            toap_pkg::OPT_TIMEOUT: want = 31'(req_regs.timeout_request);
            default:               want = req_regs.transfer_size;
        endcase
        r.option_kind = cur_opt;
        r.option_value = acc;
        r.matches_request = (acc == want);
        r.packet_end = last;
        return r;
    endfunction

    task automatic parse_ack_byte(input toap_pkg::in_word_t w);
        toap_pkg::out_word_t r;
        logic                have;
        logic [1:0]          opt;
        longint unsigned     grown;
        string               nm;
        have = 1'b0;
        r = '0;
        case (ph)
            toap_pkg::PH_OPCODE: begin
                if (!opcode_seen) opcode_seen = 1'b1;
                else open_name();
            end
            toap_pkg::PH_NAME: begin
                if (w.packet_byte == 8'h00) begin
                    opt = toap_pkg::OPT_NONE;
                    for (int k = 2; k >= 0; k--) begin
                        nm = option_name(2'(k));
                        if (live[k] && int'(name_pos) == nm.len()) opt = 2'(k);
                    end
                    ph = toap_pkg::PH_VALUE;
                    cur_opt = opt;
                    acc = '0;
                    digits_done = 1'b0;
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        nm = option_name(2'(k));
                        if (!(int'(name_pos) < nm.len() && nm[name_pos] == w.packet_byte))
                            live[k] = 1'b0;
                    end
                    if (name_pos != 4'd15) name_pos++;
                end
            end
            default: begin
                if (w.packet_byte == 8'h00) begin
                    if (cur_opt != toap_pkg::OPT_NONE) begin
                        r = value_report(w.final_byte);
                        have = 1'b1;
                    end
                    open_name();
                end else begin
                    if (!digits_done && w.packet_byte >= DIGIT_0
                            && w.packet_byte <= DIGIT_9) begin
                        grown = longint'(acc) * 10 + longint'(w.packet_byte) - 48;
                        acc = (grown > VALUE_MAX) ? 31'(VALUE_MAX) : 31'(grown);
                    end else begin
                        digits_done = 1'b1;
                    end
                    if (w.final_byte && cur_opt != toap_pkg::OPT_NONE) begin
                        r = value_report(1'b1);
                        have = 1'b1;
                    end
                end
            end
        endcase
        if (w.final_byte) begin
            if (!have) begin
                r = '0;
                r.option_kind = toap_pkg::OPT_NONE;
                r.packet_end = 1'b1;
                have = 1'b1;
            end
            clear_parse();
        end
        if (have) reports_due.push_back(r);
    endtask

    task automatic compare_field(input string field, input logic [30:0] want,
                                 input logic [30:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endtask

    task automatic check_report(input toap_pkg::out_word_t got);
        toap_pkg::out_word_t want;
        if (reports_due.size() == 0) begin
            $error("unexpected result word: kind %0d value %0d match %0b end %0b",
                   got.option_kind, got.option_value, got.matches_request, got.packet_end);
            failures++;
        end else begin
            want = reports_due.pop_front();
            compare_field("option_kind", 31'(want.option_kind), 31'(got.option_kind));
            compare_field("option_value", want.option_value, got.option_value);
            compare_field("matches_request", 31'(want.matches_request),
                          31'(got.matches_request));
            compare_field("packet_end", 31'(want.packet_end), 31'(got.packet_end));
            words_checked++;
            if (want.matches_request) matched_seen++;
            if (want.option_kind == toap_pkg::OPT_NONE) markers_seen++;
        end
    endtask

    // sender: bursts of random length, random gaps between them
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                parse_ack_byte(s_data);
                bytes_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (bytes_to_send.size() > 0) begin
                    s_data <= bytes_to_send.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = $urandom_range(0, tx_gap_max);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: short stall runs, plus long holds on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_report(m_data);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (holds_done < holds_asked) begin
                holds_done++;
                hold_left = LONG_HOLD;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < rx_stall_pct) begin
                stall_left = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[tftp_option_ack_parser_core] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [toap_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [toap_pkg::CFG_DATA_BITS-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            toap_pkg::CFG_BLKSIZE: req_regs.requested_block_size = value[15:0];
            toap_pkg::CFG_TIMEOUT: req_regs.timeout_request = value[7:0];
            toap_pkg::CFG_TSIZE:   req_regs.transfer_size = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
        pkt.push_back(8'h00);
    endtask

    task automatic commit_packet();
        toap_pkg::in_word_t w;
        for (int i = 0; i < pkt.size(); i++) begin
            w.packet_byte = pkt[i];
            w.final_byte = (i == pkt.size() - 1);
            bytes_to_send.push_back(w);
        end
        bytes_queued += pkt.size();
        packets_queued++;
    endtask

    function automatic string digit_run(input int n);
        string s = "";
        repeat (n) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        return s;
    endfunction

    function automatic string pick_name(output logic [1:0] opt);
        string s = "";
        opt = toap_pkg::OPT_NONE;
        case ($urandom_range(0, 11))
            0, 1, 2: opt = toap_pkg::OPT_BLKSIZE;
            3, 4:    opt = toap_pkg::OPT_TIMEOUT;
            5, 6:    opt = toap_pkg::OPT_TSIZE;
            7:       return "blk";
            8:       return "tsizes";
            9:       return "timeouT";
            10:      return "";
            default: begin
                repeat ($urandom_range(1, 20))
                    s = $sformatf("%s%c", s, $urandom_range(97, 122));
                return s;
            end
        endcase
        return option_name(opt);
    endfunction

    function automatic string pick_value(input logic [1:0] opt);
        string s = "";
        case ($urandom_range(0, 11))
            0, 1, 2: begin
                case (opt)
                    toap_pkg::OPT_BLKSIZE:
                        s = $sformatf("%0d", req_regs.requested_block_size);
                    toap_pkg::OPT_TIMEOUT:
                        s = $sformatf("%0d", req_regs.timeout_request);
                    default:
                        s = $sformatf("%0d", req_regs.transfer_size);
                endcase
            end
            3, 4: s = $sformatf("%0d", $urandom_range(0, 1500));
            5:    s = $sformatf("%0d", $urandom());
            6:    s = digit_run($urandom_range(10, 16));
            7: begin
                case ($urandom_range(0, 2))
                    0:       s = " ";
                    1:       s = "+";
                    default: s = "-";
                endcase
                s = $sformatf("%s%0d", s, $urandom_range(0, 9999));
            end
            8:    s = $sformatf("%0d%c%0d", $urandom_range(0, 99999), $urandom_range(33, 126),
                                $urandom_range(0, 999));
            9:    s = "";
            10:   s = $sformatf("00%0d", $urandom_range(0, 999));
            default: begin
                repeat ($urandom_range(1, 6))
                    s = $sformatf("%s%c", s, $urandom_range(1, 255));
            end
        endcase
        return s;
    endfunction

    task automatic queue_packet();
        logic [1:0] opt;
        string      nm;
        int         nopt;
        int         keep;
        pkt.delete();
        if ($urandom_range(0, 7) == 0) begin
            pkt.push_back(8'($urandom()));
            pkt.push_back(8'($urandom()));
        end else begin
            pkt.push_back(8'h00);
            pkt.push_back(8'h06);
        end
        nopt = $urandom_range(0, 4);
        repeat (nopt) begin
            nm = pick_name(opt);
            add_text(nm);
            add_text(pick_value(opt));
        end
        case ($urandom_range(0, 9))
            0: begin
                keep = $urandom_range(1, pkt.size());
                while (pkt.size() > keep) void'(pkt.pop_back());
            end
            1: if (nopt > 0) void'(pkt.pop_back());
            2: begin
                pkt.delete();
                repeat ($urandom_range(1, 12))
                    pkt.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom()));
            end
            default: ;
        endcase
        commit_packet();
    endtask

    task automatic drain();
        while (bytes_accepted != bytes_queued || reports_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        int target;
        clear_parse();
        req_regs.requested_block_size = toap_pkg::BLKSIZE_RST;
        req_regs.timeout_request = '0;
        req_regs.transfer_size = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // transfer size cut off mid-value and saturated
        pkt.delete();
        pkt.push_back(8'h06);
        pkt.push_back(8'h00);
        add_text("tsize");
        add_text("9999999999");
        void'(pkt.pop_back());
        commit_packet();
        // packet ending inside the opcode
        pkt.delete();
        pkt.push_back(8'hFF);
        commit_packet();
        // empty name, value cut off
        pkt.delete();
        pkt.push_back(8'h00);
        pkt.push_back(8'h06);
        pkt.push_back(8'h00);
        pkt.push_back(8'h35);
        commit_packet();
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    write_reg(toap_pkg::CFG_BLKSIZE, 31'h0000FFFF);
                    write_reg(toap_pkg::CFG_TIMEOUT, 31'h000000FF);
                    write_reg(toap_pkg::CFG_TSIZE, 31'h7FFFFFFF);
                end
                1: begin
                    write_reg(toap_pkg::CFG_BLKSIZE, '0);
                    write_reg(toap_pkg::CFG_TIMEOUT, '0);
                    write_reg(toap_pkg::CFG_TSIZE, '0);
                end
                default: begin
                    if ($urandom_range(0, 2) != 0)
                        write_reg(toap_pkg::CFG_BLKSIZE, 31'($urandom_range(0, 65535)));
                    if ($urandom_range(0, 2) != 0)
                        write_reg(toap_pkg::CFG_TIMEOUT, 31'($urandom_range(0, 255)));
                    if ($urandom_range(0, 2) != 0)
                        write_reg(toap_pkg::CFG_TSIZE, 31'($urandom() >> 1));
                end
            endcase
            @(posedge aclk);
            if (p == 4) begin
                tx_gap_max <= 0;
                rx_stall_pct <= 0;
            end else if (p == 2 || p == 6) begin
                tx_gap_max <= 2;
                rx_stall_pct <= 10;
                holds_asked <= holds_asked + 1;
            end else begin
                tx_gap_max <= $urandom_range(1, 12);
                rx_stall_pct <= $urandom_range(5, 60);
            end
            target = bytes_queued + BYTES_PER_PHASE;
            while (bytes_queued < target) queue_packet();
            drain();
        end

        $display("tb_top: %0d bytes in %0d packets, %0d register writes over %0d configurations",
                 bytes_accepted, packets_queued, reg_writes, NUM_PHASES + 1);
        $display("tb_top: %0d result words checked, %0d matching the request, %0d end markers",
                 words_checked, matched_seen, markers_seen);
        if (failures == 0)
            $display("[tftp_option_ack_parser_core] OK");
        else
            $display("[tftp_option_ack_parser_core] ERROR");
        $finish;
    end

endmodule
